// ----- rtl/sha_pkg.sv -----
package sha_pkg;

  typedef enum logic [1:0] {
    FUNC_ABSORB  = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD2,
    ST_OUT
  } state_t;

  // control from sequencer to round unit
  typedef struct packed {
    logic       init;    // load working vars from chaining value
    logic       step;    // run one round
    logic [5:0] rnd;
  } rctl_t;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/sha256_stream_hasher_unit.sv -----
// Absorb: bytes are taken while idle; the 64th byte of a block then starts a
//   compression (load, 64 rounds on the shared round unit, fold).
// Read: one or two padded compressions, then 8 result items, one per cycle
//   while out_stall is low.
// No new item is taken until a compression or a read is finished.
// Synchronous active-low reset loads the initial hash and clears counts.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_pkg::state_t st_r, st_nxt;
  logic [255:0] hash_r, hash_nxt;      // live chaining value
  logic [255:0] tmp_r, tmp_nxt;        // private copy during read
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [2:0]   widx_r, widx_nxt;
  logic         is_read_r, is_read_nxt;   // compression belongs to a read
  logic         pass2_r, pass2_nxt;       // read: second padded block pending
  logic [31:0]  buf_r [sha_pkg::BlockBytes/4];  // block bytes, packed big-endian
  logic [31:0]  bword_r;                  // block word for the current round
  logic [31:0]  w_word;
  logic [255:0] chain, folded;
  logic [63:0]  len;
  sha_pkg::rctl_t ctl;
  logic         acc;

  assign acc = in_valid && !in_stall;
  assign chain = is_read_r ? tmp_r : hash_r;
  assign len = bits_r + {55'd0, fill_r, 3'd0};

  // byte j of the block currently being compressed
  function automatic logic [7:0] blk_byte(input logic [5:0] j, input logic rd,
                                          input logic p2, input logic [5:0] n,
                                          input logic [7:0] b, input logic [63:0] l);
    logic [7:0] r;
    if (!rd) r = b;
    else begin
      if (!p2 && j < n) r = b;
      else if (!p2 && j == n) r = sha_pkg::PadByte;
      else r = 8'd0;
      if ((p2 || n < 6'd56) && j >= 6'd56) r = l[8*(63 - j) +: 8];
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_word[31 - 8*i -: 8] = blk_byte({rnd_r[3:0], 2'(i)}, is_read_r, pass2_r, fill_r,
                                       bword_r[31 - 8*i -: 8], len);
    end
  end

  // word for the next round is registered ahead of use, indexed by rnd_nxt
  always_ff @(posedge clk) begin
    if (acc && in_func == sha_pkg::FUNC_ABSORB)
      buf_r[fill_r[5:2]][31 - 8*fill_r[1:0] -: 8] <= in_data_byte;
    bword_r <= buf_r[rnd_nxt[3:0]];
  end

  sha_round u_round (.clk(clk), .ctl(ctl), .chain(chain), .w_in(w_word), .folded(folded));

  always_comb begin
    st_nxt = st_r; hash_nxt = hash_r; tmp_nxt = tmp_r; fill_nxt = fill_r;
    bits_nxt = bits_r; rnd_nxt = rnd_r; widx_nxt = widx_r;
    is_read_nxt = is_read_r; pass2_nxt = pass2_r;
    ctl = '{init: 1'b0, step: 1'b0, rnd: rnd_r};
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (st_r)
      sha_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (sha_pkg::func_t'(in_func))
            sha_pkg::FUNC_ABSORB: begin
              fill_nxt = fill_r + 6'd1;
              if (fill_r == 6'd63) begin
                is_read_nxt = 1'b0; st_nxt = sha_pkg::ST_LOAD;
              end
            end
            sha_pkg::FUNC_READ: begin
              is_read_nxt = 1'b1; pass2_nxt = 1'b0; tmp_nxt = hash_r;
              st_nxt = sha_pkg::ST_LOAD;
            end
            sha_pkg::FUNC_RESTART: begin
              hash_nxt = sha_pkg::InitH; fill_nxt = '0; bits_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      sha_pkg::ST_LOAD: begin
        ctl.init = 1'b1; rnd_nxt = '0; st_nxt = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        ctl.step = 1'b1; rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(sha_pkg::Rounds - 1)) st_nxt = sha_pkg::ST_FOLD;
      end
      sha_pkg::ST_FOLD: begin
        if (!is_read_r) begin
          hash_nxt = folded; bits_nxt = bits_r + 64'd512; st_nxt = sha_pkg::ST_IDLE;
        end else begin
          tmp_nxt = folded;
          if (!pass2_r && fill_r >= 6'd56) begin
            pass2_nxt = 1'b1; st_nxt = sha_pkg::ST_LOAD;
          end else begin
            widx_nxt = '0; st_nxt = sha_pkg::ST_OUT;
          end
        end
      end
      sha_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == 3'd7) begin
            is_read_nxt = 1'b0; st_nxt = sha_pkg::ST_IDLE;
          end
        end
      end
      default: st_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  assign out_digest_word = tmp_r[255 - 32*widx_r -: 32];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sha_pkg::ST_IDLE; hash_r <= sha_pkg::InitH; fill_r <= '0;
      bits_r <= '0; rnd_r <= '0; widx_r <= '0; is_read_r <= 1'b0; pass2_r <= 1'b0;
    end else begin
      st_r <= st_nxt; hash_r <= hash_nxt; fill_r <= fill_nxt; bits_r <= bits_nxt;
      rnd_r <= rnd_nxt; widx_r <= widx_nxt; is_read_r <= is_read_nxt; pass2_r <= pass2_nxt;
    end
  end

  always_ff @(posedge clk) tmp_r <= tmp_nxt;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == sha_pkg::ST_OUT) else $error("result outside output phase");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != sha_pkg::ST_IDLE |-> in_stall) else $error("item taken while busy");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> st_r == sha_pkg::ST_IDLE)
    else $error("read did not finish after last word");
  a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == sha_pkg::ST_FOLD |-> $past(st_r) == sha_pkg::ST_ROUND && rnd_r == 6'd0)
    else $error("fold without full round count");

endmodule

// ----- rtl/sha_round.sv -----
// One SHA-256 round per cycle while ctl.step is high, plus a 16-deep message schedule window.
module sha_round (
  input  logic             clk,
  input  sha_pkg::rctl_t   ctl,
  input  logic [255:0]     chain,
  input  logic [31:0]      w_in,     // block word, used for rounds 0..15
  output logic [255:0]     folded
);

  logic [31:0] v_r [8];
  logic [31:0] win_r [16];
  logic [31:0] w_cur, s0, s1, t1, t2, e, a;

  always_comb begin
    s0 = sha_pkg::rotr(win_r[1], 7) ^ sha_pkg::rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1 = sha_pkg::rotr(win_r[14], 17) ^ sha_pkg::rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    w_cur = (ctl.rnd < 6'd16) ? w_in : (s1 + win_r[9] + s0 + win_r[0]);
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
         + ((e & v_r[5]) ^ (~e & v_r[6])) + sha_pkg::round_k(ctl.rnd) + w_cur;
    t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
         + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    for (int i = 0; i < 8; i++) begin
      folded[255 - 32*i -: 32] = chain[255 - 32*i -: 32] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain[255 - 32*i -: 32];
    end else if (ctl.step) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= w_cur;
    end
  end

endmodule
